// ===== rtl/core/cube_corner_perspective_transform_assert.svh =====
// Assertion macros for the cube corner transform.
// Define NO_ASSERTIONS to compile them out.
`ifndef CUBE_CORNER_PERSPECTIVE_TRANSFORM_ASSERT_SVH
`define CUBE_CORNER_PERSPECTIVE_TRANSFORM_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication; the consequent may carry a fixed delay.
`define CCPT_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> prop) \
    else $error("ccpt: implication check failed");
// Next-cycle implication.
`define CCPT_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> prop) \
    else $error("ccpt: next-cycle check failed");
`else
`define CCPT_ASSERT_IMP(label, cond, prop)
`define CCPT_ASSERT_NXT(label, cond, prop)
`endif
`endif

// ===== rtl/core/ccpt_pkg.sv =====
`timescale 1ns / 1ps
package ccpt_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_ANGLE_X  = 3'd0;
  localparam logic [2:0] REG_ANGLE_Y  = 3'd1;
  localparam logic [2:0] REG_ANGLE_Z  = 3'd2;
  localparam logic [2:0] REG_SHIFT_X  = 3'd3;
  localparam logic [2:0] REG_SHIFT_Y  = 3'd4;
  localparam logic [2:0] REG_SHIFT_Z  = 3'd5;
  localparam logic [2:0] REG_EDGE     = 3'd6;
  localparam logic [2:0] REG_SCREEN   = 3'd7;

  // Rotation matrix: nine Q3.14 entries, row major, entry 0 in the low bits.
  typedef logic [8:0][17:0] mat_t;

  localparam mat_t MAT_IDENTITY = '{18'd16384, 18'd0, 18'd0,
                                    18'd0, 18'd16384, 18'd0,
                                    18'd0, 18'd0, 18'd16384};

  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;
  localparam logic signed [16:0] PIX_MAX = 17'sd40000;

  // Quarter-wave sine table, entry k for k = 0..90 degrees.
  typedef logic [90:0][14:0] sine_tab_t;

  // One table entry: a thirteen-term odd series in Q30, rounded half up to Q14.
  function automatic logic [14:0] sine_entry(input int k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        q;
    logic signed [63:0] sum;
    x = 64'(k) * 64'd3373259426 / 64'd180;
    x2 = (x * x) >> 30;
    term = x;
    sum = $signed(x);
    for (int n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    q = (64'(sum) + 64'd32768) >> 16;
    return (q > 64'd16384) ? 15'd16384 : q[14:0];
  endfunction

  // The whole table, evaluated when the design is elaborated.
  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    tab = '0;
    for (int k = 0; k <= 90; k++) begin
      tab[k] = sine_entry(k);
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_Q = build_sine();

  // Reduce an angle below 720 degrees to 0..359.
  function automatic logic [9:0] mod360(input logic [9:0] d);
    return (d >= 10'd360) ? d - 10'd360 : d;
  endfunction

  // Sine of a whole-degree angle in Q1.14.
  function automatic logic signed [15:0] sin_deg(input logic [9:0] d);
    logic [9:0] e;
    logic [9:0] k;
    logic       neg;
    e = mod360(d);
    if (e <= 10'd90) begin
      k = e;
      neg = 1'b0;
    end else if (e <= 10'd180) begin
      k = 10'd180 - e;
      neg = 1'b0;
    end else if (e <= 10'd270) begin
      k = e - 10'd180;
      neg = 1'b1;
    end else begin
      k = 10'd360 - e;
      neg = 1'b1;
    end
    return neg ? -$signed({1'b0, SINE_Q[k[6:0]]}) : $signed({1'b0, SINE_Q[k[6:0]]});
  endfunction

  // Cosine as the sine shifted by a quarter turn.
  function automatic logic signed [15:0] cos_deg(input logic [9:0] d);
    return sin_deg(mod360(d) + 10'd90);
  endfunction

endpackage

// ===== rtl/core/ccpt_matrix.sv =====
`timescale 1ns / 1ps
module ccpt_matrix import ccpt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       build_i,
  input  logic [8:0] angle_x_i,
  input  logic [8:0] angle_y_i,
  input  logic [8:0] angle_z_i,
  output logic       busy_o,
  output mat_t       mat_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOOK = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_WR   = 3'd4;

  logic [2:0] state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  mat_t       mat_q;

  logic signed [15:0] sx_q, cx_q, sy_q, cy_q, sz_q, cz_q;
  logic signed [15:0] a1, b1, c1, a2, b2;
  logic               n1;
  logic signed [31:0] m1_q, m2_q;
  logic signed [15:0] c1_q;
  logic               n1_q;
  logic signed [47:0] prod, term, t_q;
  logic signed [47:0] rnd;
  logic signed [17:0] entry;

  // Operands of each entry: term1 = a1*b1*c1 (negated on n1), term2 = a2*b2*one.
  always_comb begin
    a1 = '0; b1 = '0; c1 = '0; n1 = 1'b0; a2 = '0; b2 = '0;
    unique case (cnt_q)
      4'd0: begin a1 = cy_q; b1 = cz_q; c1 = ONE_Q14; end
      4'd1: begin a1 = cy_q; b1 = sz_q; c1 = ONE_Q14; n1 = 1'b1; end
      4'd2: begin a1 = sy_q; b1 = ONE_Q14; c1 = ONE_Q14; end
      4'd3: begin a1 = sx_q; b1 = sy_q; c1 = cz_q; a2 = cx_q; b2 = sz_q; end
      4'd4: begin a1 = sx_q; b1 = sy_q; c1 = sz_q; n1 = 1'b1; a2 = cx_q; b2 = cz_q; end
      4'd5: begin a1 = sx_q; b1 = cy_q; c1 = ONE_Q14; n1 = 1'b1; end
      4'd6: begin a1 = cx_q; b1 = sy_q; c1 = cz_q; n1 = 1'b1; a2 = sx_q; b2 = sz_q; end
      4'd7: begin a1 = cx_q; b1 = sy_q; c1 = sz_q; a2 = sx_q; b2 = cz_q; end
      4'd8: begin a1 = cx_q; b1 = cy_q; c1 = ONE_Q14; end
      default: begin a1 = '0; end
    endcase
  end

  // Second product, sum, then round half up to Q14 and saturate.
  always_comb begin
    prod = m1_q * c1_q;
    term = n1_q ? -prod : prod;
    rnd = (t_q + 48'sd134217728) >>> 28;
    if (rnd > 48'sd131071) begin
      entry = 18'sd131071;
    end else if (rnd < -48'sd131072) begin
      entry = -18'sd131072;
    end else begin
      entry = rnd[17:0];
    end
  end

  // Sequencer: a lookup state, then the multiply, accumulate and write states for each entry.
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    unique case (state_q)
      ST_LOOK: begin state_d = ST_MUL; cnt_d = '0; end
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = ST_WR;
      ST_WR: begin
        if (cnt_q == 4'd8) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_MUL;
          cnt_d = cnt_q + 4'd1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (build_i) begin
      state_d = ST_LOOK;
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      mat_q <= MAT_IDENTITY;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      if (state_q == ST_WR) begin
        mat_q[cnt_q] <= entry;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOOK) begin
      sx_q <= sin_deg({1'b0, angle_x_i});
      cx_q <= cos_deg({1'b0, angle_x_i});
      sy_q <= sin_deg({1'b0, angle_y_i});
      cy_q <= cos_deg({1'b0, angle_y_i});
      sz_q <= sin_deg({1'b0, angle_z_i});
      cz_q <= cos_deg({1'b0, angle_z_i});
    end
    if (state_q == ST_MUL) begin
      m1_q <= a1 * b1;
      m2_q <= a2 * b2;
      c1_q <= c1;
      n1_q <= n1;
    end
    if (state_q == ST_ACC) begin
      t_q <= term + (48'(m2_q) <<< 14);
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign mat_o = mat_q;

endmodule

// ===== rtl/core/ccpt_rotate.sv =====
`timescale 1ns / 1ps
module ccpt_rotate import ccpt_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [2:0]                 corner_i,
  input  mat_t                       mat_i,
  input  logic [7:0]                 cube_edge_i,
  input  logic signed [8:0]          shift_x_i,
  input  logic signed [8:0]          shift_y_i,
  input  logic signed [8:0]          shift_z_i,
  output logic                       valid_o,
  output logic signed [FRAC_BITS+11:0] r_x_o,
  output logic signed [FRAC_BITS+11:0] r_y_o,
  output logic signed [FRAC_BITS+11:0] r_z_o
);

  localparam int W  = 12 + FRAC_BITS;
  localparam int AW = 29 + FRAC_BITS;
  localparam logic signed [AW-1:0] HALF = signed'({{(AW-14){1'b0}}, 1'b1, 13'b0});
  localparam logic signed [AW-1:0] CMAX = signed'({{(AW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [AW-1:0] CMIN = -CMAX - 1;

  logic                v1_q, v2_q, v3_q;
  logic [2:0]          sgn_q;
  logic signed [26:0]  p_q [9];
  logic signed [28:0]  acc_d [3];
  logic signed [28:0]  acc_q [3];
  logic signed [AW-1:0] ext [3];
  logic signed [AW-1:0] tot [3];
  logic signed [AW-1:0] sh [3];
  logic signed [W-1:0] r_d [3];
  logic signed [W-1:0] r_q [3];

  // Sum of the three signed products in each row.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_d[i] = '0;
      for (int j = 0; j < 3; j++) begin
        acc_d[i] = sgn_q[j] ? acc_d[i] + 29'(p_q[i*3+j]) : acc_d[i] - 29'(p_q[i*3+j]);
      end
    end
  end

  // Scale by half the edge, round half up to the coordinate format, shift, saturate.
  always_comb begin
    sh[0] = AW'(shift_x_i) <<< FRAC_BITS;
    sh[1] = AW'(shift_y_i) <<< FRAC_BITS;
    sh[2] = AW'(shift_z_i) <<< FRAC_BITS;
    for (int i = 0; i < 3; i++) begin
      ext[i] = AW'(acc_q[i]) <<< (FRAC_BITS - 1);
      tot[i] = ((ext[i] + HALF) >>> 14) + sh[i];
      if (tot[i] > CMAX) begin
        r_d[i] = CMAX[W-1:0];
      end else if (tot[i] < CMIN) begin
        r_d[i] = CMIN[W-1:0];
      end else begin
        r_d[i] = tot[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Corner signs and matrix times edge, then row sums, then rounded coordinates.
  always_ff @(posedge clk_i) begin
    sgn_q <= {corner_i[2], corner_i[1], corner_i[0] ^ corner_i[1]};
    for (int i = 0; i < 9; i++) begin
      p_q[i] <= $signed(mat_i[i]) * $signed({1'b0, cube_edge_i});
    end
    acc_q <= acc_d;
    r_q <= r_d;
  end

  assign valid_o = v3_q;
  assign r_x_o = r_q[0];
  assign r_y_o = r_q[1];
  assign r_z_o = r_q[2];

endmodule

// ===== rtl/core/ccpt_divider.sv =====
`timescale 1ns / 1ps
module ccpt_divider #(
  parameter int FRAC_BITS = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [2*FRAC_BITS+19:0]   num_x_i,
  input  logic [2*FRAC_BITS+19:0]   num_y_i,
  input  logic [FRAC_BITS+11:0]     den_i,
  output logic                      valid_o,
  output logic [FRAC_BITS+14:0]     quo_x_o,
  output logic [FRAC_BITS+14:0]     quo_y_o
);

  // Restoring division, one quotient bit per stage, both lanes share the divisor.
  localparam int REMW = 12 + FRAC_BITS;
  localparam int QB   = 15 + FRAC_BITS;
  localparam int RQW  = REMW + QB;

  logic [1:0][RQW-1:0] rq_q [1:QB];
  logic [REMW-1:0]     den_q [1:QB];
  logic [QB:1]         v_q;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [1:0][RQW-1:0] src;
    logic [1:0][RQW-1:0] nxt;
    logic [REMW-1:0]     den;
    logic                vin;
    logic [REMW:0]       t [2];
    logic [REMW:0]       diff [2];

    if (k == 0) begin : g_first
      assign src[0] = RQW'(num_x_i);
      assign src[1] = RQW'(num_y_i);
      assign den = den_i;
      assign vin = valid_i;
    end else begin : g_next
      assign src = rq_q[k];
      assign den = den_q[k];
      assign vin = v_q[k];
    end

    // Trial subtraction of the divisor from the partial remainder.
    always_comb begin
      for (int l = 0; l < 2; l++) begin
        t[l] = {src[l][RQW-1 -: REMW], src[l][QB-1]};
        diff[l] = t[l] - {1'b0, den};
        if (!diff[l][REMW]) begin
          nxt[l] = {diff[l][REMW-1:0], src[l][QB-2:0], 1'b1};
        end else begin
          nxt[l] = {t[l][REMW-1:0], src[l][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else begin
        v_q[k+1] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      rq_q[k+1] <= nxt;
      den_q[k+1] <= den;
    end
  end

  assign valid_o = v_q[QB];
  assign quo_x_o = rq_q[QB][0][QB-1:0];
  assign quo_y_o = rq_q[QB][1][QB-1:0];

endmodule

// ===== rtl/core/ccpt_project.sv =====
`timescale 1ns / 1ps
module ccpt_project import ccpt_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic signed [FRAC_BITS+11:0] r_x_i,
  input  logic signed [FRAC_BITS+11:0] r_y_i,
  input  logic signed [FRAC_BITS+11:0] r_z_i,
  input  logic [9:0]                   screen_half_i,
  output logic                         done_o,
  output logic signed [16:0]           pixel_x_o,
  output logic signed [16:0]           pixel_y_o
);

  localparam int W    = 12 + FRAC_BITS;
  localparam int REMW = 12 + FRAC_BITS;
  localparam int QB   = 15 + FRAC_BITS;
  localparam int NB   = W + 8 + FRAC_BITS;
  localparam int CW   = W + 8;
  localparam int SW   = 4 * W + 18;
  localparam logic signed [W:0]   LIM   = (W+1)'(180) <<< FRAC_BITS;
  localparam logic signed [W+4:0] LIM_W = (W+5)'(180) <<< FRAC_BITS;
  localparam logic signed [CW-1:0] BIAS = signed'({{(CW-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}});

  // Projection front stage.
  logic signed [W:0]   d;
  logic signed [W+4:0] dd, d11;
  logic                div_ok, eq_ok;
  logic [W-1:0]        mag_x, mag_y;
  logic signed [W+6:0] rx7, ry7, alt_x, alt_y;

  logic                va_q;
  logic [NB-1:0]       nx_q, ny_q;
  logic [REMW-1:0]     den_q;
  logic [SW-1:0]       side_a_q;
  logic [SW-1:0]       side_q [1:QB];

  logic                dv;
  logic [QB-1:0]       quo_x, quo_y;

  logic [SW-1:0]       side;
  logic signed [CW-1:0] qx, qy, cx, cy, shw;
  logic signed [CW-1:0] sx_q, sy_q;
  logic                v1_q, done_q;
  logic signed [16:0]  px_q, py_q;

  // Divide when 11 times the depth exceeds the limit, that is 0 < p < 11.
  always_comb begin
    d = (W+1)'(r_z_i) + LIM;
    dd = (W+5)'(d);
    d11 = (dd <<< 3) + (dd <<< 1) + dd;
    div_ok = (d > 0) && (d11 > LIM_W);
    eq_ok = (d11 == LIM_W);
    mag_x = r_x_i[W-1] ? W'(-r_x_i) : W'(r_x_i);
    mag_y = r_y_i[W-1] ? W'(-r_y_i) : W'(r_y_i);
    rx7 = (W+7)'(r_x_i);
    ry7 = (W+7)'(r_y_i);
    alt_x = (rx7 <<< 6) + (rx7 <<< 5) + (rx7 <<< 2);
    alt_y = (ry7 <<< 6) + (ry7 <<< 5) + (ry7 <<< 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    nx_q <= (NB'(mag_x) * NB'(180)) << FRAC_BITS;
    ny_q <= (NB'(mag_y) * NB'(180)) << FRAC_BITS;
    den_q <= d[REMW-1:0];
    side_a_q <= {div_ok, eq_ok, r_x_i[W-1], r_y_i[W-1], alt_x, alt_y, r_x_i, r_y_i};
  end

  ccpt_divider #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (va_q),
    .num_x_i (nx_q),
    .num_y_i (ny_q),
    .den_i   (den_q),
    .valid_o (dv),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y)
  );

  // Side data keeps pace with the divider stages.
  always_ff @(posedge clk_i) begin
    side_q[1] <= side_a_q;
    for (int k = 2; k <= QB; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end

  // Pick the projected coordinate and add the screen offset.
  always_comb begin
    side = side_q[QB];
    qx = CW'(quo_x);
    qy = CW'(quo_y);
    if (side[4*W+15]) begin
      qx = -qx;
    end
    if (side[4*W+14]) begin
      qy = -qy;
    end
    if (side[4*W+17]) begin
      cx = qx;
      cy = qy;
    end else if (side[4*W+16]) begin
      cx = CW'($signed(side[2*W-1 -: W]));
      cy = CW'($signed(side[W-1:0]));
    end else begin
      cx = CW'($signed(side[4*W+13 -: W+7]));
      cy = CW'($signed(side[3*W+6 -: W+7]));
    end
    shw = CW'(screen_half_i) << FRAC_BITS;
  end

  // Truncate toward zero to whole pixels and saturate.
  function automatic logic signed [16:0] to_pix(input logic signed [CW-1:0] s);
    logic signed [CW-1:0] tr;
    tr = (s < 0) ? ((s + BIAS) >>> FRAC_BITS) : (s >>> FRAC_BITS);
    if (tr > CW'(PIX_MAX)) begin
      return PIX_MAX;
    end else if (tr < -CW'(PIX_MAX)) begin
      return -PIX_MAX;
    end
    return tr[16:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q <= dv;
      done_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sx_q <= cx + shw;
    sy_q <= cy + shw;
    px_q <= to_pix(sx_q);
    py_q <= to_pix(sy_q);
  end

  assign done_o = done_q;
  assign pixel_x_o = px_q;
  assign pixel_y_o = py_q;

endmodule

// ===== rtl/core/cube_corner_perspective_transform.sv =====
`timescale 1ns / 1ps
// Cube corner perspective transform.
// Pulse start with a corner index on corner_i while busy is low; the item is
// taken at that clock edge. A new corner may be taken in every cycle while busy is low.
// Each corner comes back on pixel_x_o / pixel_y_o with done_o high for one
// cycle, after three rotation stages, one projection stage, the restoring
// divider with one quotient bit per stage, and two output stages.
// Registers are written over the cfg channel (index, data, valid/ready);
// cfg_ready_o is always high. Writing an angle rebuilds the rotation matrix
// in a sequencer that shares three multipliers: busy is high while it runs
// and no corner is taken meanwhile. Other registers apply at once.
// Reset clears the pipeline, restores the register defaults and loads the
// identity matrix; no build pass follows reset. The receiver cannot stall:
// results are presented once and must be taken in that cycle.
`include "cube_corner_perspective_transform_assert.svh"
module cube_corner_perspective_transform import ccpt_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         corner_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [9:0]         cfg_data_i,
  output logic               done_o,
  output logic signed [16:0] pixel_x_o,
  output logic signed [16:0] pixel_y_o
);

  localparam int LATENCY = 21 + FRAC_BITS;

  logic [8:0]        angle_x_q, angle_y_q, angle_z_q;
  logic signed [8:0] shift_x_q, shift_y_q, shift_z_q;
  logic [7:0]        cube_edge_q;
  logic [9:0]        screen_half_q;
  logic              cfg_xfer, build;
  logic              mat_busy;
  mat_t              mat;
  logic              accept;
  logic              rv;
  logic signed [FRAC_BITS+11:0] rx, ry, rz;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer = cfg_valid_i && cfg_ready_o;
  assign build = cfg_xfer && ((cfg_index_i == REG_ANGLE_X) || (cfg_index_i == REG_ANGLE_Y) ||
                              (cfg_index_i == REG_ANGLE_Z));

  // Configuration registers, written on a cfg transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_x_q <= '0;
      angle_y_q <= '0;
      angle_z_q <= '0;
      shift_x_q <= '0;
      shift_y_q <= '0;
      shift_z_q <= '0;
      cube_edge_q <= 8'd75;
      screen_half_q <= 10'd300;
    end else if (cfg_xfer) begin
      unique case (cfg_index_i)
        REG_ANGLE_X: angle_x_q <= cfg_data_i[8:0];
        REG_ANGLE_Y: angle_y_q <= cfg_data_i[8:0];
        REG_ANGLE_Z: angle_z_q <= cfg_data_i[8:0];
        REG_SHIFT_X: shift_x_q <= cfg_data_i[8:0];
        REG_SHIFT_Y: shift_y_q <= cfg_data_i[8:0];
        REG_SHIFT_Z: shift_z_q <= cfg_data_i[8:0];
        REG_EDGE:    cube_edge_q <= cfg_data_i[7:0];
        REG_SCREEN:  screen_half_q <= cfg_data_i;
        default:     cube_edge_q <= cube_edge_q;
      endcase
    end
  end

  ccpt_matrix u_matrix (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .build_i   (build),
    .angle_x_i (angle_x_q),
    .angle_y_i (angle_y_q),
    .angle_z_i (angle_z_q),
    .busy_o    (mat_busy),
    .mat_o     (mat)
  );

  assign busy = mat_busy;
  assign accept = start && !busy;

  ccpt_rotate #(
    .FRAC_BITS (FRAC_BITS)
  ) u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .corner_i    (corner_i),
    .mat_i       (mat),
    .cube_edge_i (cube_edge_q),
    .shift_x_i   (shift_x_q),
    .shift_y_i   (shift_y_q),
    .shift_z_i   (shift_z_q),
    .valid_o     (rv),
    .r_x_o       (rx),
    .r_y_o       (ry),
    .r_z_o       (rz)
  );

  ccpt_project #(
    .FRAC_BITS (FRAC_BITS)
  ) u_project (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (rv),
    .r_x_i         (rx),
    .r_y_i         (ry),
    .r_z_i         (rz),
    .screen_half_i (screen_half_q),
    .done_o        (done_o),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o)
  );

  // Every taken corner comes out after the fixed pipeline latency.
  `CCPT_ASSERT_IMP(a_result_latency, accept, ##LATENCY done_o)
  // An angle write starts a matrix rebuild, which holds off new corners.
  `CCPT_ASSERT_NXT(a_build_busy, build, busy)

endmodule

// ===== verif/tb_cube_corner_perspective_transform.sv =====
`timescale 1ns / 1ps
module tb_cube_corner_perspective_transform;
  import ccpt_pkg::*;

  typedef struct {
    logic signed [16:0] px;
    logic signed [16:0] py;
  } pixel_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         corner_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [9:0]         cfg_data_i = '0;
  logic               done_o;
  logic signed [16:0] pixel_x_o;
  logic signed [16:0] pixel_y_o;

  cube_corner_perspective_transform uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .corner_i(corner_i),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .done_o(done_o), .pixel_x_o(pixel_x_o), .pixel_y_o(pixel_y_o)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the block's registers and rotation matrix.
  longint sine_tab [0:90];
  longint rot [0:8];
  int unsigned ang_x, ang_y, ang_z;
  longint sft_x, sft_y, sft_z;
  longint edge_len, half_screen;

  logic [2:0] corner_queue [$];
  pixel_t     pixel_queue [$];
  int         errors = 0;
  int         accepted = 0;
  bit         calm = 1'b0;
  bit         pausing = 1'b0;
  int         cycles = 0;

  // Quarter-wave sine in Q1.14 from a Taylor series in Q30.
  function automatic void fill_sine();
    longint unsigned x, x2, term;
    longint sum;
    for (int k = 0; k <= 90; k++) begin
      x = longint'(k) * 64'd3373259426 / 64'd180;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int n = 1; n <= 12; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum -= term;
        else sum += term;
      end
      if (sum < 0) sum = 0;
      sum = (sum + 32768) >>> 16;
      sine_tab[k] = (sum > 16384) ? 16384 : sum;
    end
  endfunction

  function automatic longint sine_of(int unsigned d);
    int unsigned e;
    e = d % 360;
    if (e <= 90) return sine_tab[e];
    if (e <= 180) return sine_tab[180 - e];
    if (e <= 270) return -sine_tab[e - 180];
    return -sine_tab[360 - e];
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Rotation matrix Rx*Ry*Rz, each entry rounded half up from Q42 to Q14.
  function automatic void rebuild_rotation();
    longint sx, cx, sy, cy, sz, cz, one;
    longint q [0:8];
    one = 16384;
    sx = sine_of(ang_x); cx = sine_of(ang_x % 360 + 90);
    sy = sine_of(ang_y); cy = sine_of(ang_y % 360 + 90);
    sz = sine_of(ang_z); cz = sine_of(ang_z % 360 + 90);
    q[0] = cy * cz * one;
    q[1] = -cy * sz * one;
    q[2] = sy * one * one;
    q[3] = sx * sy * cz + cx * sz * one;
    q[4] = -sx * sy * sz + cx * cz * one;
    q[5] = -sx * cy * one;
    q[6] = -cx * sy * cz + sx * sz * one;
    q[7] = cx * sy * sz + sx * cz * one;
    q[8] = cx * cy * one;
    for (int i = 0; i < 9; i++) rot[i] = clamp((q[i] + (64'sd1 <<< 27)) >>> 28, -131072, 131071);
  endfunction

  function automatic longint sext9(logic [9:0] v);
    return longint'($signed(v[8:0]));
  endfunction

  // Register write as the block sees it.
  function automatic void apply_register(logic [2:0] idx, logic [9:0] val);
    case (idx)
      REG_ANGLE_X: begin ang_x = val[8:0]; rebuild_rotation(); end
      REG_ANGLE_Y: begin ang_y = val[8:0]; rebuild_rotation(); end
      REG_ANGLE_Z: begin ang_z = val[8:0]; rebuild_rotation(); end
      REG_SHIFT_X: sft_x = sext9(val);
      REG_SHIFT_Y: sft_y = sext9(val);
      REG_SHIFT_Z: sft_z = sext9(val);
      REG_EDGE:    edge_len = val[7:0];
      REG_SCREEN:  half_screen = val;
      default: ;
    endcase
  endfunction

  function automatic logic signed [16:0] screen_coord(longint c);
    longint s;
    s = c + half_screen * 256;
    return 17'(clamp(s / 256, -40000, 40000));
  endfunction

  // Rotate, translate, project and offset one corner.
  function automatic pixel_t project_corner(logic [2:0] c);
    longint h, acc, d, lim, px, py;
    longint v [0:2];
    longint sh [0:2];
    longint r [0:2];
    pixel_t res;
    h = edge_len * 128;
    v[0] = (c[0] ^ c[1]) ? h : -h;
    v[1] = c[1] ? h : -h;
    v[2] = c[2] ? h : -h;
    sh[0] = sft_x; sh[1] = sft_y; sh[2] = sft_z;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += rot[i * 3 + j] * v[j];
      r[i] = clamp(((acc + 8192) >>> 14) + sh[i] * 256, -524288, 524287);
    end
    lim = 180 * 256;
    d = r[2] + lim;
    if (d > 0 && 11 * d > lim) begin
      px = r[0] * lim / d;
      py = r[1] * lim / d;
    end else if (11 * d == lim) begin
      px = r[0];
      py = r[1];
    end else begin
      px = r[0] * 100;
      py = r[1] * 100;
    end
    res.px = screen_coord(px);
    res.py = screen_coord(py);
    return res;
  endfunction

  task automatic report(string what, logic signed [16:0] got, logic signed [16:0] want);
    $display("%0t %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Driver: present queued corners, record the prediction of each transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        pixel_queue.push_back(project_corner(corner_i));
        void'(corner_queue.pop_front());
        accepted++;
        if (accepted % 97 == 0) pausing = 1'b1;
      end
      if (pausing && pixel_queue.size() == 0) pausing = 1'b0;
      if (corner_queue.size() == 0 || pausing || (!calm && $urandom_range(0, 99) < 37)) begin
        start <= 1'b0;
      end else begin
        start <= 1'b1;
        corner_i <= corner_queue[0];
      end
    end
  end

  // Monitor: compare each result with the oldest prediction.
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && done_o) begin
      if (pixel_queue.size() == 0) begin
        $display("%0t unexpected result %0d %0d", $realtime, pixel_x_o, pixel_y_o);
        errors++;
      end else begin
        want = pixel_queue.pop_front();
        if (pixel_x_o !== want.px) report("pixel_x", pixel_x_o, want.px);
        if (pixel_y_o !== want.py) report("pixel_y", pixel_y_o, want.py);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 400000) begin
      $display("cube_corner_perspective_transform: mismatch");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [9:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(idx, val);
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every queued corner is taken and every result is back.
  task automatic drain();
    while (corner_queue.size() != 0 || start || pixel_queue.size() != 0) @(posedge clk_i);
    repeat (35) @(posedge clk_i);
  endtask

  task automatic queue_corners(int n);
    for (int i = 0; i < n; i++) corner_queue.push_back(3'($urandom_range(0, 7)));
  endtask

  initial begin
    fill_sine();
    ang_x = 0; ang_y = 0; ang_z = 0;
    sft_x = 0; sft_y = 0; sft_z = 0;
    edge_len = 75; half_screen = 300;
    rebuild_rotation();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every corner with the reset settings.
    for (int c = 0; c < 8; c++) corner_queue.push_back(3'(c));
    drain();
    // Extremes: the largest y angle, extreme x and y shifts, the largest edge and screen offset.
    write_reg(REG_ANGLE_X, 10'd360);
    write_reg(REG_ANGLE_Y, 10'd511);
    write_reg(REG_ANGLE_Z, 10'd90);
    write_reg(REG_SHIFT_X, 10'h0FF);
    write_reg(REG_SHIFT_Y, 10'h100);
    write_reg(REG_SHIFT_Z, 10'd200);
    write_reg(REG_EDGE, 10'h0FF);
    write_reg(REG_SCREEN, 10'h3FF);
    for (int c = 0; c < 8; c++) corner_queue.push_back(3'(c));
    drain();
    // Depth exactly at the eye (z = -180) and behind it.
    write_reg(REG_ANGLE_X, 10'd0);
    write_reg(REG_ANGLE_Y, 10'd0);
    write_reg(REG_ANGLE_Z, 10'd0);
    write_reg(REG_EDGE, 10'd20);
    write_reg(REG_SHIFT_Z, 10'($signed(-170)));
    write_reg(REG_SCREEN, 10'd0);
    write_reg(REG_SHIFT_X, 10'($signed(-200)));
    corner_queue.push_back(3'd0);
    corner_queue.push_back(3'd5);
    drain();
    write_reg(REG_SHIFT_Z, 10'($signed(-200)));
    write_reg(REG_EDGE, 10'd150);
    for (int c = 0; c < 8; c += 2) corner_queue.push_back(3'(c));
    drain();

    // Random phases, each with fresh settings.
    for (int ph = 0; ph < 17; ph++) begin
      calm = (ph == 6 || ph == 7);
      for (int r = 0; r < 8; r++) begin
        if ($urandom_range(0, 3) == 0 || r > 2) write_reg(3'(r), 10'($urandom_range(0, 1023)));
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_SHIFT_Z, 10'($signed($urandom_range(0, 60)) - 200));
      queue_corners(50);
      drain();
    end

    if (errors == 0) begin
      $display("cube_corner_perspective_transform: match");
    end else begin
      $display("cube_corner_perspective_transform: mismatch");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ccpt_pkg.sv
rtl/core/ccpt_matrix.sv
rtl/core/ccpt_rotate.sv
rtl/core/ccpt_divider.sv
rtl/core/ccpt_project.sv
rtl/core/cube_corner_perspective_transform.sv
verif/tb_cube_corner_perspective_transform.sv
